// ===== hdl/cfr_pkg.sv =====
// Shared types, codes and the CRC-16/MODBUS byte update for the frame receiver.
package cfr_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] START_MARKER_RST = 8'd126;
	localparam logic [7:0] END_MARKER_RST   = 8'd127;

	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd1;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_CRC_BAD  = 2'd2,
		KIND_END_BAD  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload;
		logic [7:0]  ftype;
		logic [7:0]  seq;
		logic [15:0] length;
		logic        done;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/cfr_crc16.sv =====
// Running CRC-16/MODBUS register with a one-byte-per-cycle update while update is high.
module cfr_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        update,
	input  logic        clear,
	input  logic [7:0]  data,
	output logic [15:0] crc
);
	import cfr_pkg::*;

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (clear) begin
			crc_q <= CRC_INIT;
		end else if (update) begin
			crc_q <= crc16_byte(crc_q, data);
		end
	end

	assign crc = crc_q;
endmodule

// ===== hdl/cfr_deframer.sv =====
// Frame parser: marker hunt, header capture, payload pass-through and status check.
module cfr_deframer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      data,
	input  logic [7:0]      start_marker,
	input  logic [7:0]      end_marker,
	output logic            has_result,
	output cfr_pkg::result_t result
);
	import cfr_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CRC     = 3'd3,
		PH_END     = 3'd4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [15:0] length_q, length_d;
	logic [7:0]  ftype_q, ftype_d;
	logic [7:0]  seq_q, seq_d;
	logic [15:0] rx_crc_q, rx_crc_d;
	logic [15:0] crc;
	logic [15:0] count_inc;
	logic        crc_update;
	logic        crc_clear;

	cfr_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.update (crc_update),
		.clear  (crc_clear),
		.data   (data),
		.crc    (crc)
	);

	assign count_inc = count_q + 16'd1;

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		length_d   = length_q;
		ftype_d    = ftype_q;
		seq_d      = seq_q;
		rx_crc_d   = rx_crc_q;
		crc_update = 1'b0;
		crc_clear  = 1'b0;
		has_result = 1'b0;
		result.kind    = KIND_PAYLOAD;
		result.payload = 8'd0;
		result.ftype   = ftype_q;
		result.seq     = seq_q;
		result.length  = length_q;
		result.done    = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				case (count_q[1:0])
					2'd0: length_d = {8'd0, data};
					2'd1: length_d = {data, length_q[7:0]};
					2'd2: ftype_d = data;
					default: seq_d = data;
				endcase
				if (count_q >= 16'd3) begin
					count_d = 16'd0;
					phase_d = (length_q != 16'd0) ? PH_PAYLOAD : PH_CRC;
				end else begin
					count_d = count_inc;
				end
			end
			PH_PAYLOAD: begin
				crc_update     = take;
				has_result     = 1'b1;
				result.payload = data;
				if (count_inc >= length_q) begin
					count_d = 16'd0;
					phase_d = PH_CRC;
				end else begin
					count_d = count_inc;
				end
			end
			PH_CRC: begin
				if (count_q == 16'd0) begin
					rx_crc_d = {8'd0, data};
					count_d  = 16'd1;
				end else begin
					rx_crc_d = {data, rx_crc_q[7:0]};
					count_d  = 16'd0;
					phase_d  = PH_END;
				end
			end
			PH_END: begin
				has_result  = 1'b1;
				result.done = 1'b1;
				if (data != end_marker) begin
					result.kind = KIND_END_BAD;
				end else if (crc != rx_crc_q) begin
					result.kind = KIND_CRC_BAD;
				end else begin
					result.kind = KIND_GOOD;
				end
				phase_d   = PH_HUNT;
				count_d   = 16'd0;
				length_d  = 16'd0;
				ftype_d   = 8'd0;
				seq_d     = 8'd0;
				rx_crc_d  = 16'd0;
				crc_clear = take;
			end
			default: begin
				if (data == start_marker) begin
					phase_d   = PH_HEADER;
					count_d   = 16'd0;
					length_d  = 16'd0;
					ftype_d   = 8'd0;
					seq_d     = 8'd0;
					rx_crc_d  = 16'd0;
					crc_clear = take;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			count_q  <= 16'd0;
			length_q <= 16'd0;
			ftype_q  <= 8'd0;
			seq_q    <= 8'd0;
			rx_crc_q <= 16'd0;
		end else if (take) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			length_q <= length_d;
			ftype_q  <= ftype_d;
			seq_q    <= seq_d;
			rx_crc_q <= rx_crc_d;
		end
	end
endmodule

// ===== hdl/crc_frame_receiver.sv =====
// Top level of the byte frame receiver with CRC-16/MODBUS check.
//
// Input channel rx_valid/rx_stall carries one link byte per item in rx_byte.
// Result channel res_valid/res_stall carries one result item: a payload byte
// (result_kind 0) or a frame status (good, CRC mismatch, bad end marker) with
// frame_done set. Header fields of the current frame travel with every result.
// Configuration writes (cfg_valid/cfg_ready, index 0 start marker, index 1 end
// marker) are always taken; cfg_ready is tied high.
// A byte is registered in byte_s1 at acceptance and processed when it is taken;
// its result is registered in out_q for the result port. One byte per cycle is
// sustained while res_stall is low; the byte-wide CRC update is the longest path.
// When the receiver stalls, the result is held and one more byte may wait in
// the input register; bytes that give no result still pass through the parser.
// Reset clears the parser to hunting for the start marker, sets the markers to
// 126 and 127, and empties both registers.
module crc_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rx_valid,
	output logic                          rx_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [1:0]                    result_kind,
	output logic [7:0]                    payload_byte,
	output logic [7:0]                    frame_type,
	output logic [7:0]                    seq_number,
	output logic [15:0]                   frame_length,
	output logic                          frame_done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import cfr_pkg::*;

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    result;
	logic       has_result;
	logic       out_free;
	logic       take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_START_MARKER) begin
				start_marker_q <= cfg_data;
			end else if (cfg_index == CFG_END_MARKER) begin
				end_marker_q <= cfg_data;
			end
		end
	end

	assign out_free = !out_valid_q || !res_stall;
	assign take     = valid_s1 && (!has_result || out_free);
	assign rx_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	cfr_deframer u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data         (byte_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.has_result   (has_result),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			out_q <= result;
		end
	end

	assign res_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign payload_byte = out_q.payload;
	assign frame_type   = out_q.ftype;
	assign seq_number   = out_q.seq;
	assign frame_length = out_q.length;
	assign frame_done   = out_q.done;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_stall) |-> !(take && has_result))
		else $error("held result would be overwritten");

	a_status_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_done) |-> (payload_byte == 8'd0 && result_kind != KIND_PAYLOAD))
		else $error("status result carries payload data");
`endif
endmodule
